// File: hw/rtl/dlcs_pkg.sv
// ----------------------------------------------------------------------------
// Delay loop calibration search package
// Shared request and response types, command codes and default values.
// ----------------------------------------------------------------------------
package dlcs_pkg;

   // Default count width and timer tick period in milliseconds.
   localparam int unsigned COUNT_WIDTH_DEFAULT    = 32;
   localparam int unsigned TICK_PERIOD_MS_DEFAULT = 10;

   // Width of the fine_bits register and its value after reset.
   localparam int unsigned FINE_BITS_WIDTH = 5;
   localparam logic [FINE_BITS_WIDTH-1:0] FINE_BITS_RESET = 5'd8;

   // Command codes carried in a request.
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef struct packed {
      logic command;
      logic tick_passed;
   } dlcs_req_type;

   typedef struct packed {
      logic [31:0] trial_count;
      logic        finished;
      logic [31:0] per_ms_count;
      logic        overflow;
   } dlcs_rsp_type;

   // Status handed from the search step to the response formatter.
   typedef struct packed {
      logic finished;
      logic overflow;
   } dlcs_status_type;

endpackage

// File: hw/rtl/delay_loop_calibration_search.sv
// ----------------------------------------------------------------------------
// Delay loop calibration search
// Steers a loop count search against a timer tick: coarse doubling, then a
// successive approximation of the lower bits, then the per-ms count.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_stall  dlcs_req_type (command, tick)
//   rsp_     out        rsp_valid / rsp_stall  dlcs_rsp_type (count, status)
//   csr_     in         csr_wr_en              csr_wr_data = fine_bits
//
// A request is registered when accepted and its response is registered when
// the search step fires, which a stalled response can hold off.
// One request can be accepted every cycle while the response is not stalled;
// the rate is set by the single search step between the two registers.
// Reset is synchronous and active high; it clears the search to idle with a
// count of one and sets fine_bits to eight.
// A stalled response holds; the request register then holds too and req_stall
// rises, so no request is lost while the result waits.
// ----------------------------------------------------------------------------
module delay_loop_calibration_search #(
   parameter int unsigned COUNT_WIDTH    = dlcs_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned TICK_PERIOD_MS = dlcs_pkg::TICK_PERIOD_MS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dlcs_pkg::dlcs_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dlcs_pkg::dlcs_rsp_type                rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [dlcs_pkg::FINE_BITS_WIDTH-1:0]  csr_wr_data
);
   import dlcs_pkg::*;

   // The configuration register is read by the search step on every request.
   logic [FINE_BITS_WIDTH-1:0] fine_bits_ff;

   // Request register and its valid flag.
   logic         in_valid_ff, in_valid_in;
   dlcs_req_type in_req_ff;

   // Result register and its valid flag.
   logic         rsp_valid_ff, rsp_valid_in;
   dlcs_rsp_type rsp_data_ff;

   logic            rsp_load, step_en, req_accept;
   logic [COUNT_WIDTH-1:0] next_count, next_quot;
   dlcs_status_type next_status;
   dlcs_rsp_type    next_rsp;

   // The result register can take a new value when it is empty or being read.
   // The search step fires whenever a registered request can move there.
   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign step_en    = in_valid_ff && rsp_load;
   assign req_stall  = in_valid_ff && !rsp_load;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = step_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_bits_ff <= FINE_BITS_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fine_bits_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_req_ff <= req_data;
      end
      if (step_en) begin
         rsp_data_ff <= next_rsp;
      end
   end

   dlcs_step #(
      .COUNT_WIDTH    (COUNT_WIDTH),
      .TICK_PERIOD_MS (TICK_PERIOD_MS)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .req         (in_req_ff),
      .fine_bits   (fine_bits_ff),
      .next_count  (next_count),
      .next_quot   (next_quot),
      .next_status (next_status)
   );

   dlcs_format #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_format (
      .count  (next_count),
      .quot   (next_quot),
      .status (next_status),
      .rsp    (next_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result appears only after a registered request took its search step.
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("response appeared without a registered request");

   // A search step always lands in the result register.
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("search step did not produce a response");

   // Overflow is reported only together with a finished search.
   a_ovf_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.overflow |-> rsp_data_ff.finished)
      else $error("overflow flagged on an unfinished search");

   // A finished search never ends with a count of zero.
   a_final_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.finished |-> rsp_data_ff.trial_count != '0)
      else $error("finished search reported a zero count");

endmodule

// File: hw/rtl/dlcs_step.sv
// ----------------------------------------------------------------------------
// Delay loop calibration search step
// Search state and its next value for one request. The count is kept both
// raw and as quotient and remainder by the tick period, so the per-ms value
// is ready without a divider.
// ----------------------------------------------------------------------------
module dlcs_step #(
   parameter int unsigned COUNT_WIDTH    = dlcs_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned TICK_PERIOD_MS = dlcs_pkg::TICK_PERIOD_MS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step_en,
   input  dlcs_pkg::dlcs_req_type                 req,
   input  logic [dlcs_pkg::FINE_BITS_WIDTH-1:0]   fine_bits,
   output logic [COUNT_WIDTH-1:0]                 next_count,
   output logic [COUNT_WIDTH-1:0]                 next_quot,
   output dlcs_pkg::dlcs_status_type              next_status
);
   import dlcs_pkg::*;

   localparam int unsigned CW = COUNT_WIDTH;
   localparam int unsigned RW = $clog2(TICK_PERIOD_MS + 1);
   localparam int unsigned SW = RW + 2;

   localparam logic [RW:0]          PERIOD_R1 = (RW + 1)'(TICK_PERIOD_MS);
   localparam logic signed [SW-1:0] PERIOD_S  = SW'(TICK_PERIOD_MS);
   localparam logic [CW-1:0]        ONE_Q     = CW'(1 / TICK_PERIOD_MS);
   localparam logic [RW-1:0]        ONE_R     = RW'(1 % TICK_PERIOD_MS);
   localparam logic [CW-1:0]        TWO_Q     = CW'(2 / TICK_PERIOD_MS);
   localparam logic [RW-1:0]        TWO_R     = RW'(2 % TICK_PERIOD_MS);

   typedef enum logic [1:0] {PH_IDLE, PH_COARSE, PH_FINE, PH_DONE} phase_type;

   typedef struct packed {
      logic [CW-1:0] q;
      logic [RW-1:0] r;
   } qr_type;

   // Value shifted right by one, in quotient and remainder form.
   function automatic qr_type half_qr(qr_type a);
      qr_type        res;
      logic [RW:0]   s;
      s     = {1'b0, a.r} + (a.q[0] ? PERIOD_R1 : '0);
      res.q = a.q >> 1;
      res.r = s[RW:1];
      return res;
   endfunction

   // Value shifted left by one; the caller guarantees the top bit is clear.
   function automatic qr_type double_qr(qr_type a);
      qr_type        res;
      logic [RW:0]   s;
      logic          ge;
      s     = {a.r, 1'b0};
      ge    = (s >= PERIOD_R1);
      res.r = ge ? RW'(s - PERIOD_R1) : s[RW-1:0];
      res.q = {a.q[CW-2:0], ge};
      return res;
   endfunction

   // c - sub + add, where sub is contained in c and add is disjoint from it.
   function automatic qr_type combine_qr(qr_type c, qr_type sub, qr_type add);
      qr_type               res;
      logic signed [SW-1:0] rsum;
      logic [CW-1:0]        corr;
      rsum = $signed({2'b00, c.r}) - $signed({2'b00, sub.r}) + $signed({2'b00, add.r});
      if (rsum < 0) begin
         res.r = RW'(rsum + PERIOD_S);
         corr  = '1;
      end else if (rsum >= PERIOD_S) begin
         res.r = RW'(rsum - PERIOD_S);
         corr  = CW'(1);
      end else begin
         res.r = RW'(rsum);
         corr  = '0;
      end
      res.q = c.q - sub.q + add.q + corr;
      return res;
   endfunction

   logic [CW-1:0]              count_ff, count_in;
   qr_type                     count_qr_ff, count_qr_in;
   logic [CW-1:0]              test_ff, test_in;
   qr_type                     test_qr_ff, test_qr_in;
   logic [FINE_BITS_WIDTH-1:0] bits_done_ff, bits_done_in;
   phase_type                  phase_ff, phase_in;
   logic                       ovf_ff, ovf_in;

   // Intermediate values of the coarse-to-fine hand-over and the fine step.
   logic [CW-1:0]              half_raw, quarter_raw, base_raw, test_half_raw;
   qr_type                     half_v, quarter_v, sub_v, test_half_v;
   logic [FINE_BITS_WIDTH-1:0] bits_next;

   always_comb begin
      count_in     = count_ff;
      count_qr_in  = count_qr_ff;
      test_in      = test_ff;
      test_qr_in   = test_qr_ff;
      bits_done_in = bits_done_ff;
      phase_in     = phase_ff;
      ovf_in       = ovf_ff;

      half_raw      = count_ff >> 1;
      quarter_raw   = half_raw >> 1;
      half_v        = half_qr(count_qr_ff);
      quarter_v     = half_qr(half_v);
      sub_v         = req.tick_passed ? test_qr_ff : '0;
      base_raw      = req.tick_passed ? (count_ff & ~test_ff) : count_ff;
      test_half_raw = test_ff >> 1;
      test_half_v   = half_qr(test_qr_ff);
      bits_next     = FINE_BITS_WIDTH'(bits_done_ff + 1'b1);

      if (req.command == CMD_START) begin
         count_in     = CW'(2);
         count_qr_in  = '{q: TWO_Q, r: TWO_R};
         test_in      = '0;
         test_qr_in   = '0;
         bits_done_in = '0;
         ovf_in       = 1'b0;
         phase_in     = PH_COARSE;
      end else begin
         unique case (phase_ff)
            PH_COARSE: begin
               if (!req.tick_passed) begin
                  if (count_ff[CW-1]) begin
                     ovf_in   = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     count_in    = count_ff << 1;
                     count_qr_in = double_qr(count_qr_ff);
                  end
               end else begin
                  // Halve, then propose the bit just below the leading one.
                  test_in      = quarter_raw;
                  test_qr_in   = quarter_v;
                  bits_done_in = '0;
                  if (quarter_raw == '0 || fine_bits == '0) begin
                     count_in    = half_raw;
                     count_qr_in = half_v;
                     phase_in    = PH_DONE;
                  end else begin
                     count_in    = half_raw | quarter_raw;
                     count_qr_in = combine_qr(half_v, '0, quarter_v);
                     phase_in    = PH_FINE;
                  end
               end
            end
            PH_FINE: begin
               test_in      = test_half_raw;
               test_qr_in   = test_half_v;
               bits_done_in = bits_next;
               if (test_half_raw == '0 || bits_next >= fine_bits) begin
                  count_in    = base_raw;
                  count_qr_in = combine_qr(count_qr_ff, sub_v, '0);
                  phase_in    = PH_DONE;
               end else begin
                  count_in    = base_raw | test_half_raw;
                  count_qr_in = combine_qr(count_qr_ff, sub_v, test_half_v);
                  phase_in    = PH_FINE;
               end
            end
            PH_IDLE, PH_DONE: begin
               // Reports are ignored; the last result is repeated.
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(1);
         count_qr_ff  <= '{q: ONE_Q, r: ONE_R};
         test_ff      <= '0;
         test_qr_ff   <= '0;
         bits_done_ff <= '0;
         phase_ff     <= PH_IDLE;
         ovf_ff       <= 1'b0;
      end else if (step_en) begin
         count_ff     <= count_in;
         count_qr_ff  <= count_qr_in;
         test_ff      <= test_in;
         test_qr_ff   <= test_qr_in;
         bits_done_ff <= bits_done_in;
         phase_ff     <= phase_in;
         ovf_ff       <= ovf_in;
      end
   end

   assign next_count           = count_in;
   assign next_quot            = count_qr_in.q;
   assign next_status.finished = (phase_in == PH_DONE);
   assign next_status.overflow = (phase_in == PH_DONE) && ovf_in;

endmodule

// File: hw/rtl/dlcs_format.sv
// ----------------------------------------------------------------------------
// Delay loop calibration response formatter
// Saturates the count and the per-ms quotient to 32 bits and packs them.
// ----------------------------------------------------------------------------
module dlcs_format #(
   parameter int unsigned COUNT_WIDTH = dlcs_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic [COUNT_WIDTH-1:0]       count,
   input  logic [COUNT_WIDTH-1:0]       quot,
   input  dlcs_pkg::dlcs_status_type    status,
   output dlcs_pkg::dlcs_rsp_type       rsp
);
   import dlcs_pkg::*;

   logic [31:0] count_sat, quot_sat;

   generate
      if (COUNT_WIDTH > 32) begin : g_wide
         assign count_sat = (|count[COUNT_WIDTH-1:32]) ? '1 : count[31:0];
         assign quot_sat  = (|quot[COUNT_WIDTH-1:32])  ? '1 : quot[31:0];
      end else begin : g_narrow
         assign count_sat = 32'(count);
         assign quot_sat  = 32'(quot);
      end
   endgenerate

   assign rsp.trial_count  = count_sat;
   assign rsp.finished     = status.finished;
   assign rsp.per_ms_count = status.finished ? quot_sat : '0;
   assign rsp.overflow     = status.overflow;

endmodule

// File: test/dlcs_checker.sv
// ----------------------------------------------------------------------------
// Delay loop calibration search checker
// Watches the request, response and register ports of the search controller,
// predicts every response from its own copy of the search state and compares
// the responses in order, field by field.
// ----------------------------------------------------------------------------
module dlcs_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  dlcs_pkg::dlcs_req_type                req_data,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  dlcs_pkg::dlcs_rsp_type                rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [dlcs_pkg::FINE_BITS_WIDTH-1:0]  csr_wr_data,
   output int unsigned                           failures,
   output int unsigned                           pending
);
   import dlcs_pkg::*;

   localparam int unsigned CW = COUNT_WIDTH_DEFAULT;
   localparam int unsigned MAX_REPORTS = 10;

   typedef enum logic [1:0] {
      SEARCH_IDLE,
      SEARCH_COARSE,
      SEARCH_FINE,
      SEARCH_DONE
   } search_phase_type;

   logic [CW-1:0]              count_reg;
   logic [CW-1:0]              probe_bit;
   logic [FINE_BITS_WIDTH-1:0] refined;
   logic [FINE_BITS_WIDTH-1:0] fine_bits;
   logic                       overflowed;
   search_phase_type           stage;
   dlcs_rsp_type               expected_rsp_q[$];

   // Moves the probe one bit down and sets it, unless the bits or the budget
   // of refined bits have run out.
   function automatic void propose_fine_bit();
      probe_bit = probe_bit >> 1;
      if (probe_bit == '0 || refined >= fine_bits) begin
         stage = SEARCH_DONE;
      end else begin
         count_reg = count_reg | probe_bit;
         stage = SEARCH_FINE;
      end
   endfunction

   function automatic dlcs_rsp_type search_step(input dlcs_req_type r);
      dlcs_rsp_type rsp;
      if (r.command == CMD_START) begin
         count_reg = CW'(2);
         probe_bit = '0;
         refined = '0;
         overflowed = 1'b0;
         stage = SEARCH_COARSE;
      end else if (stage == SEARCH_COARSE) begin
         if (!r.tick_passed) begin
            if (count_reg[CW-1]) begin
               overflowed = 1'b1;
               stage = SEARCH_DONE;
            end else begin
               count_reg = count_reg << 1;
            end
         end else begin
            count_reg = count_reg >> 1;
            probe_bit = count_reg;
            refined = '0;
            propose_fine_bit();
         end
      end else if (stage == SEARCH_FINE) begin
         if (r.tick_passed) begin
            count_reg = count_reg & ~probe_bit;
         end
         refined = refined + 1'b1;
         propose_fine_bit();
      end
      rsp.trial_count = count_reg;
      rsp.finished = (stage == SEARCH_DONE);
      rsp.per_ms_count = rsp.finished ? count_reg / TICK_PERIOD_MS_DEFAULT : '0;
      rsp.overflow = rsp.finished && overflowed;
      return rsp;
   endfunction

   always @(posedge clock) begin
      dlcs_rsp_type exp;
      if (reset) begin
         count_reg = CW'(1);
         probe_bit = '0;
         refined = '0;
         fine_bits = FINE_BITS_RESET;
         overflowed = 1'b0;
         stage = SEARCH_IDLE;
         expected_rsp_q.delete();
         failures = 0;
         pending <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(search_step(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("unexpected response: count %0d finished %0b per_ms %0d ovf %0b",
                           rsp_data.trial_count, rsp_data.finished,
                           rsp_data.per_ms_count, rsp_data.overflow);
               end
            end else begin
               exp = expected_rsp_q.pop_front();
               if (rsp_data.trial_count !== exp.trial_count ||
                   rsp_data.finished !== exp.finished ||
                   rsp_data.per_ms_count !== exp.per_ms_count ||
                   rsp_data.overflow !== exp.overflow) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display("mismatch: expected count %0d finished %0b per_ms %0d ovf %0b",
                              exp.trial_count, exp.finished, exp.per_ms_count,
                              exp.overflow);
                     $display("          actual   count %0d finished %0b per_ms %0d ovf %0b",
                              rsp_data.trial_count, rsp_data.finished,
                              rsp_data.per_ms_count, rsp_data.overflow);
                  end
               end
            end
         end
         // The register takes effect after any request accepted on this edge.
         if (csr_wr_en) begin
            fine_bits = csr_wr_data;
         end
         pending <= expected_rsp_q.size();
      end
   end

endmodule

// File: test/delay_loop_calibration_search_tb.sv
// ----------------------------------------------------------------------------
// Delay loop calibration search testbench
// Drives start commands and trial outcomes into the search controller, with
// random gaps on the request side and random stalls on the response side,
// and steps fine_bits through several settings between phases. A checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module delay_loop_calibration_search_tb;
   import dlcs_pkg::*;

   localparam int unsigned PHASE_COUNT     = 6;
   localparam int unsigned PHASE_REQUESTS  = 150;
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam int unsigned DRAIN_CYCLES    = 8;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   dlcs_req_type               req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   dlcs_rsp_type               rsp_data;
   logic                       csr_wr_en;
   logic [FINE_BITS_WIDTH-1:0] csr_wr_data;
   int unsigned                failures;
   int unsigned                pending;

   // Knobs shared by the request and response processes. They only shape
   // the timing, never the expected values, so the exact cycle at which a
   // change is seen does not matter.
   bit          idle_enabled;
   int unsigned gap_pct;
   int unsigned stall_pct;
   bit          hold_off_pending;
   int unsigned requests_sent;

   delay_loop_calibration_search uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dlcs_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: a healthy run needs far fewer cycles than this.
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Response side. Random stall bursts of random length, plus one long
   // hold-off on request so that the block backs up into the request port.
   initial begin
      int unsigned burst;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 99) < stall_pct) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one request, after an optional gap, and returns on the edge at
   // which it is accepted. The valid stays high afterwards so that the next
   // request can follow back to back; a caller that has nothing more to send
   // lowers it on that same edge.
   task automatic send_request(input logic cmd, input logic tick);
      int unsigned gap;
      gap = 0;
      if (idle_enabled && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 10);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{command: cmd, tick_passed: tick};
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // Waits until every response is back, then writes fine_bits. The first
   // edge lets the checker's count catch up with a request accepted just now.
   task automatic write_fine_bits(input logic [FINE_BITS_WIDTH-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One calibration as firmware would run it: a start, a run of trials with
   // no tick while the count doubles, the trial whose tick ends the coarse
   // search, then a random number of fine trials. Extra trials past the end
   // check that the final result is repeated. Now and then a few stray
   // reports come first, which continue whatever search was left open, and
   // now and then the sequence breaks off early.
   task automatic run_calibration();
      int unsigned coarse_len;
      int unsigned fine_len;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) send_request(CMD_REPORT, 1'($urandom_range(0, 1)));
      end
      send_request(CMD_START, 1'($urandom_range(0, 1)));
      // About one calibration in six runs the doubling into the top bit.
      if ($urandom_range(0, 5) == 0) begin
         coarse_len = 31 + $urandom_range(0, 1);
      end else begin
         coarse_len = $urandom_range(0, 30);
      end
      for (int i = 0; i < coarse_len; i++) begin
         if ($urandom_range(0, 99) == 0) return;
         send_request(CMD_REPORT, 1'b0);
      end
      send_request(CMD_REPORT, 1'b1);
      fine_len = $urandom_range(0, 33);
      for (int i = 0; i < fine_len; i++) begin
         if ($urandom_range(0, 99) == 0) return;
         send_request(CMD_REPORT, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [FINE_BITS_WIDTH-1:0] fine_plan [PHASE_COUNT];
      int unsigned gap_plan [PHASE_COUNT];
      int unsigned stall_plan [PHASE_COUNT];
      int unsigned phase_start;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idle_enabled = 1'b0;
      gap_pct = 0;
      stall_pct = 0;
      hold_off_pending = 1'b0;
      requests_sent = 0;

      // Both extremes of fine_bits, a single bit, a random value and the
      // reset value again. The last phase runs without any idling.
      fine_plan = '{5'd31, 5'd0, 5'd1, 5'd0, 5'd8, 5'd31};
      fine_plan[3] = FINE_BITS_WIDTH'($urandom_range(2, 30));
      gap_plan = '{20, 0, 5, 30, 10, 0};
      stall_plan = '{20, 0, 30, 10, 40, 0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with fine_bits still at its reset value. Reports while
      // idle are ignored and show a count of one.
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_REPORT, 1'b1);
      // A tick on the very first trial halves the count to one, which leaves
      // no bit to refine, so the search ends at once.
      send_request(CMD_START, 1'b1);
      send_request(CMD_REPORT, 1'b1);
      // Reports after the end repeat the final result.
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_REPORT, 1'b1);
      // A start during a search aborts it, and a start right after a start
      // begins again from two.
      send_request(CMD_START, 1'b0);
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_START, 1'b0);
      send_request(CMD_START, 1'b1);
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_REPORT, 1'b1);
      // Fine trials with and without a tick until the probe bit runs out, then reports past the end.
      send_request(CMD_REPORT, 1'b1);
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_REPORT, 1'b1);
      // Open a search and leave it in the fine phase, so that the first
      // register write below lands in the middle of a calibration.
      send_request(CMD_START, 1'b0);
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_REPORT, 1'b0);
      send_request(CMD_REPORT, 1'b1);

      // Random part, one phase per fine_bits setting. Stray reports at the
      // head of a phase resume a search cut short in the phase before.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_fine_bits(fine_plan[p]);
         send_request(CMD_REPORT, 1'($urandom_range(0, 1)));
         send_request(CMD_REPORT, 1'($urandom_range(0, 1)));
         gap_pct = gap_plan[p];
         stall_pct = stall_plan[p];
         idle_enabled = (p != PHASE_COUNT - 1);
         // The long hold-off falls in a phase where requests come nearly
         // back to back, so the block fills up and stalls its request port.
         if (p == 2) begin
            hold_off_pending = 1'b1;
         end
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            run_calibration();
         end
      end

      // Drain: wait for every response, then a few cycles for anything stray.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: delay_loop_calibration_search.f
hw/rtl/dlcs_pkg.sv
hw/rtl/dlcs_step.sv
hw/rtl/dlcs_format.sv
hw/rtl/delay_loop_calibration_search.sv
test/dlcs_checker.sv
test/delay_loop_calibration_search_tb.sv
